// ----- rtl/fecho_pkg.sv -----
// Package for the feedback echo block: widths, fixed-point constants,
// register indexes and the rounding and saturation helpers.
// No dependencies; every other file imports it.
`default_nettype none

package fecho_pkg;

	// Echo memory depth per channel; a power of two so the pointers wrap freely.
	localparam int DELAY_DEPTH = 131072;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);

	localparam int SAMPLE_W  = 24;
	localparam int GAIN_W    = 16;
	localparam int DELAY_W   = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int WIDE_W    = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 2'd2;

	// Q1.15 unity and the fixed 0.8 gain.
	localparam logic [GAIN_W-1:0] Q15_ONE          = 16'd32768;
	localparam logic [GAIN_W-1:0] GAIN_POINT_EIGHT = 16'd26214;

	localparam logic signed [WIDE_W-1:0] Q15_HALF = 48'sd16384;
	localparam logic signed [WIDE_W-1:0] S24_MAX  = 48'sd8388607;
	localparam logic signed [WIDE_W-1:0] S24_MIN  = -48'sd8388608;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Control from the sequencer to each channel datapath.
	typedef struct packed {
		logic  accept;    // input beat taken, memory read issued
		logic  st1;       // read data present
		logic  st2;       // stored sample selected, wet scaling
		logic  st3;       // gain products
		logic  commit;    // memory write back and output load
		addr_t rd_addr;
		addr_t wr_addr;
		logic  rd_valid;  // the read entry has been written since reset
		logic  zero_dly;  // read hits the entry being written
	} fecho_ctl_t;

	// Q15 product to integer, round to nearest with ties toward plus infinity.
	function automatic logic signed [WIDE_W-1:0] rnd_q15(input logic signed [WIDE_W-1:0] p);
		logic signed [WIDE_W-1:0] t;
		t = p + Q15_HALF;
		return t >>> 15;
	endfunction

	// Clip to the signed 24-bit range.
	function automatic sample_t sat24(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] c;
		if (v > S24_MAX) begin
			c = S24_MAX;
		end else if (v < S24_MIN) begin
			c = S24_MIN;
		end else begin
			c = v;
		end
		return c[SAMPLE_W-1:0];
	endfunction

	// Gains above unity act as unity.
	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return (g > Q15_ONE) ? Q15_ONE : g;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fecho_in_if.sv -----
// Input channel of the feedback echo: one stereo frame per beat.
// Depends on fecho_pkg.
`default_nettype none

interface fecho_in_if
	import fecho_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t sample_left;
	sample_t sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

`default_nettype wire

// ----- rtl/fecho_out_if.sv -----
// Output channel of the feedback echo: one mixed stereo frame per beat.
// Depends on fecho_pkg.
`default_nettype none

interface fecho_out_if
	import fecho_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t out_left;
	sample_t out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

// ----- rtl/fecho_mem.sv -----
// One channel's echo memory: one write port, one read port, registered read data.
// Depends on fecho_pkg.
`default_nettype none

module fecho_mem
	import fecho_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    re,
	input  wire addr_t   raddr,
	output sample_t      rdata,
	input  wire logic    we,
	input  wire addr_t   waddr,
	input  wire sample_t wdata
);

	sample_t mem [DELAY_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, read data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fecho_chan.sv -----
// Datapath of one channel: echo memory, scaling stages, write back and output register.
// Depends on fecho_pkg and fecho_mem.
`default_nettype none

module fecho_chan
	import fecho_pkg::*;
(
	input  wire logic              clk,
	input  wire fecho_ctl_t        ctl,
	input  wire sample_t           dry,
	input  wire logic [GAIN_W-1:0] fb_gain,
	input  wire logic [GAIN_W-1:0] mix_gain,
	output sample_t                out_q
);

	sample_t                  dry_s1;
	sample_t                  rdata;
	sample_t                  stored_s2;
	sample_t                  mem_s2;
	sample_t                  wet_s3;
	logic signed [40:0]       pfb_s4;
	logic signed [40:0]       pmix_s4;
	logic signed [40:0]       pdry_s4;
	logic signed [38:0]       stored_c;
	logic signed [38:0]       wet_c;
	sample_t                  delayed;
	logic signed [WIDE_W-1:0] fb_sum;
	logic signed [WIDE_W-1:0] mix_sum;
	sample_t                  wb_data;

	fecho_mem u_mem (
		.clk   (clk),
		.re    (ctl.accept),
		.raddr (ctl.rd_addr),
		.rdata (rdata),
		.we    (ctl.commit),
		.waddr (ctl.wr_addr),
		.wdata (wb_data)
	);

	// Capture the dry sample with the input beat.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			dry_s1 <= dry;
		end
	end

	// Dry sample scaled by 0.8; unwritten entries read as zero.
	assign stored_c = dry_s1 * $signed({1'b0, GAIN_POINT_EIGHT[14:0]});
	always_ff @(posedge clk) begin
		if (ctl.st1) begin
			stored_s2 <= sat24(rnd_q15(48'(stored_c)));
			mem_s2    <= ctl.rd_valid ? rdata : '0;
		end
	end

	// With zero delay the read takes this frame's stored sample instead of the memory data.
	assign delayed = ctl.zero_dly ? stored_s2 : mem_s2;
	assign wet_c   = delayed * $signed({1'b0, GAIN_POINT_EIGHT[14:0]});
	always_ff @(posedge clk) begin
		if (ctl.st2) begin
			wet_s3 <= sat24(rnd_q15(48'(wet_c)));
		end
	end

	// Feedback, wet mix and dry mix products, one multiplier each.
	always_ff @(posedge clk) begin
		if (ctl.st3) begin
			pfb_s4  <= wet_s3 * $signed({1'b0, fb_gain});
			pmix_s4 <= wet_s3 * $signed({1'b0, mix_gain});
			pdry_s4 <= dry_s1 * $signed({1'b0, Q15_ONE - mix_gain});
		end
	end

	// Write back the stored sample plus feedback, and load the output.
	assign fb_sum  = 48'(stored_s2) + rnd_q15(48'(pfb_s4));
	assign wb_data = sat24(fb_sum);
	assign mix_sum = 48'(pmix_s4) + 48'(pdry_s4);
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_q <= sat24(rnd_q15(mix_sum));
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fecho_ctrl.sv -----
// Sequencer: stage strobes, write pointer, fill mark, read address and output valid.
// Depends on fecho_pkg.
`default_nettype none

module fecho_ctrl
	import fecho_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire logic [DELAY_W-1:0] delay,
	output fecho_ctl_t              ctl
);

	logic  v1_q;
	logic  v2_q;
	logic  v3_q;
	logic  v4_q;
	logic  out_vld_q;
	addr_t wp_q;
	logic  wrapped_q;
	logic  rd_valid_s1;
	logic  zero_dly_s1;
	logic  accept;
	logic  commit;
	addr_t rd_addr;

	// One frame in flight; the output register frees the front end.
	assign in_ready = !(v1_q || v2_q || v3_q || v4_q);
	assign accept   = in_valid && in_ready;
	assign commit   = v4_q && (!out_vld_q || out_ready);
	assign rd_addr  = wp_q - delay[ADDR_W-1:0];

	// Stage tracking and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			v4_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			v1_q <= accept;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q || (v4_q && !commit);
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Write pointer and fill mark: entries below the pointer are written until the first wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (commit) begin
			wp_q <= wp_q + addr_t'(1);
			if (wp_q == '1) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// Read qualifiers taken with the input beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_valid_s1 <= wrapped_q || (rd_addr < wp_q);
			zero_dly_s1 <= (delay[ADDR_W-1:0] == '0);
		end
	end

	assign out_valid = out_vld_q;

	always_comb begin
		ctl          = '0;
		ctl.accept   = accept;
		ctl.st1      = v1_q;
		ctl.st2      = v2_q;
		ctl.st3      = v3_q;
		ctl.commit   = commit;
		ctl.rd_addr  = rd_addr;
		ctl.wr_addr  = wp_q;
		ctl.rd_valid = rd_valid_s1;
		ctl.zero_dly = zero_dly_s1;
	end

`ifndef SYNTHESIS
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v1_q, v2_q, v3_q, v4_q}))
		else $error("more than one frame in the datapath");
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> wp_q == $past(wp_q) + addr_t'(1))
		else $error("write pointer did not advance on write back");
	a_wp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(wp_q))
		else $error("write pointer moved without write back");
	a_fill_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wrapped_q))
		else $error("fill mark cleared outside reset");
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_vld_q)
		else $error("output valid missing after write back");
`endif

endmodule

`default_nettype wire

// ----- rtl/feedback_echo_delay_top.sv -----
// Feedback echo, stereo: each input beat is one frame (sample_left, sample_right),
// each output beat is one mixed frame (out_left, out_right). Channels are valid/ready;
// a beat moves on a rising edge with valid and ready both high.
// Configuration is a plain write port: cfg_we, cfg_index (0 delay_samples,
// 1 feedback_gain, 2 mix_level) and cfg_data; other indexes are ignored. Gains above
// unity are held at unity. Write configuration only while no frame is in flight.
// Each frame walks through a five-step sequence around the echo memory (read, dry
// scaling, wet scaling, gain products, write back); the output beat becomes valid
// after the write back, and the next read waits for the previous write back, so a
// new frame is not taken until the last one is written back.
// The result sits in an output register, so a new frame is taken while a finished
// result waits; a stalled receiver holds the write back of the next frame until the
// register frees.
// Reset clears the configuration, the write pointer and the fill mark. The echo
// memory itself is not swept: entries not yet written since reset read as zero, so
// frames are taken right after reset.
// Depends on fecho_pkg, fecho_in_if, fecho_out_if, fecho_ctrl and fecho_chan.
`default_nettype none

module feedback_echo_delay_top
	import fecho_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	fecho_in_if.sink                  in_ch,
	fecho_out_if.source               out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [DELAY_W-1:0] delay_q;
	logic [GAIN_W-1:0]  fb_q;
	logic [GAIN_W-1:0]  mix_q;
	fecho_ctl_t         ctl;
	sample_t            out_l;
	sample_t            out_r;

	// Configuration registers, gains held at unity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			fb_q    <= '0;
			mix_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY:    delay_q <= cfg_data[DELAY_W-1:0];
				CFG_FEEDBACK: fb_q    <= clamp_gain(cfg_data[GAIN_W-1:0]);
				CFG_MIX:      mix_q   <= clamp_gain(cfg_data[GAIN_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	fecho_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.delay     (delay_q),
		.ctl       (ctl)
	);

	fecho_chan u_left (
		.clk      (clk),
		.ctl      (ctl),
		.dry      (in_ch.sample_left),
		.fb_gain  (fb_q),
		.mix_gain (mix_q),
		.out_q    (out_l)
	);

	fecho_chan u_right (
		.clk      (clk),
		.ctl      (ctl),
		.dry      (in_ch.sample_right),
		.fb_gain  (fb_q),
		.mix_gain (mix_q),
		.out_q    (out_r)
	);

	assign out_ch.out_left  = out_l;
	assign out_ch.out_right = out_r;

endmodule

`default_nettype wire
